### rtl/core/nrfp_pkg.sv
// Shared types, constants and helper functions of the RMC field parser.
`timescale 1ns / 1ps
`default_nettype none

package nrfp_pkg;

    // Fields at this position and beyond produce no record.
    localparam int unsigned FIELD_COUNT = 13;
    localparam logic [19:0] VALUE_LIMIT = 20'd999999;

    localparam logic [7:0] POINT_CHAR = 8'h2E;
    localparam logic [7:0] SEPARATOR_RESET = 8'd44;

    localparam logic [3:0] FIELD_LAST_KNOWN = 4'd12;

    localparam int unsigned IN_DATA_W = 8;
    localparam int unsigned OUT_DATA_W = 160;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_UTC    = 3'd1,
        KIND_CHAR   = 3'd2,
        KIND_LAT    = 3'd3,
        KIND_LON    = 3'd4,
        KIND_DEC    = 3'd5,
        KIND_DATE   = 3'd6,
        KIND_TAIL   = 3'd7
    } field_kind_t;

    // Per-sentence working state.
    typedef struct packed {
        logic [3:0]  field_counter;
        logic [7:0]  char_position;
        logic [19:0] accum_a;
        logic [19:0] accum_b;
        logic [19:0] accum_c;
        logic [19:0] accum_d;
        logic        point_seen;
        logic [7:0]  first_seen_char;
        logic [63:0] text_shift;
    } parse_state_t;

    // One decoded field record.
    typedef struct packed {
        logic [3:0]  field_index;
        logic        present;
        logic [19:0] part_a;
        logic [19:0] part_b;
        logic [19:0] part_c;
        logic [19:0] part_d;
        logic [7:0]  first_char;
        logic [63:0] text;
        logic        last_of_sentence;
    } field_rec_t;

    function automatic field_kind_t kind_of(input logic [3:0] idx);
        field_kind_t k;
        begin
            unique case (idx)
                4'd0:    k = KIND_HEADER;
                4'd1:    k = KIND_UTC;
                4'd3:    k = KIND_LAT;
                4'd5:    k = KIND_LON;
                4'd7:    k = KIND_DEC;
                4'd8:    k = KIND_DEC;
                4'd9:    k = KIND_DATE;
                4'd10:   k = KIND_DEC;
                4'd12:   k = KIND_TAIL;
                default: k = KIND_CHAR;
            endcase
            return k;
        end
    endfunction

    // Appends one decimal digit and saturates; other characters leave the value.
    function automatic logic [19:0] add_digit(input logic [19:0] acc, input logic [7:0] ch);
        logic [23:0] v;
        begin
            v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {20'd0, ch[3:0]};
            if (ch < 8'h30 || ch > 8'h39)
                return acc;
            else if (v > {4'd0, VALUE_LIMIT})
                return VALUE_LIMIT;
            else
                return v[19:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/nrfp_field_decode.sv
// Combinational step: folds one character into the field state and forms the record.
`timescale 1ns / 1ps
`default_nettype none

module nrfp_field_decode
    import nrfp_pkg::*;
(
    input  parse_state_t state_cur,
    input  logic [7:0]   char_code,
    input  logic         end_of_sentence,
    input  logic [7:0]   separator_char,
    output parse_state_t state_next,
    output field_rec_t   rec,
    output logic         rec_valid
);

    logic         is_sep;
    logic         active;
    parse_state_t taken;
    logic [7:0]   p;
    logic [2:0]   byte_idx;

    assign is_sep = (char_code == separator_char);
    assign active = (state_cur.field_counter < 4'(FIELD_COUNT));
    assign p = state_cur.char_position;

    always_comb
    begin
        taken = state_cur;
        byte_idx = 3'd0;
        if (active && !is_sep)
        begin
            if (p == 8'd0)
                taken.first_seen_char = char_code;
            unique case (kind_of(state_cur.field_counter))
                KIND_HEADER:
                begin
                    byte_idx = p[2:0];
                    if (p < 8'd8)
                        taken.text_shift = state_cur.text_shift
                            | ({56'd0, char_code} << {byte_idx, 3'b000});
                end
                KIND_TAIL:
                begin
                    byte_idx = 3'(p - 8'd1);
                    if (p >= 8'd1 && p <= 8'd8)
                        taken.text_shift = state_cur.text_shift
                            | ({56'd0, char_code} << {byte_idx, 3'b000});
                end
                KIND_UTC:
                begin
                    if (p < 8'd2)
                        taken.accum_a = add_digit(state_cur.accum_a, char_code);
                    else if (p < 8'd4)
                        taken.accum_b = add_digit(state_cur.accum_b, char_code);
                    else if (p < 8'd6)
                        taken.accum_c = add_digit(state_cur.accum_c, char_code);
                    else if (p >= 8'd7)
                        taken.accum_d = add_digit(state_cur.accum_d, char_code);
                end
                KIND_LAT:
                begin
                    if (p < 8'd2)
                        taken.accum_a = add_digit(state_cur.accum_a, char_code);
                    else if (p < 8'd4)
                        taken.accum_b = add_digit(state_cur.accum_b, char_code);
                    else if (p >= 8'd5)
                        taken.accum_c = add_digit(state_cur.accum_c, char_code);
                end
                KIND_LON:
                begin
                    if (p < 8'd3)
                        taken.accum_a = add_digit(state_cur.accum_a, char_code);
                    else if (p < 8'd5)
                        taken.accum_b = add_digit(state_cur.accum_b, char_code);
                    else if (p >= 8'd6)
                        taken.accum_c = add_digit(state_cur.accum_c, char_code);
                end
                KIND_DATE:
                begin
                    if (p < 8'd2)
                        taken.accum_a = add_digit(state_cur.accum_a, char_code);
                    else if (p < 8'd4)
                        taken.accum_b = add_digit(state_cur.accum_b, char_code);
                    else
                        taken.accum_c = add_digit(state_cur.accum_c, char_code);
                end
                KIND_DEC:
                begin
                    // Only the first point splits integer from fraction.
                    if (char_code == POINT_CHAR && !state_cur.point_seen)
                        taken.point_seen = 1'b1;
                    else if (state_cur.point_seen)
                        taken.accum_b = add_digit(state_cur.accum_b, char_code);
                    else
                        taken.accum_a = add_digit(state_cur.accum_a, char_code);
                end
                default:
                begin
                end
            endcase
            if (p != 8'hFF)
                taken.char_position = p + 8'd1;
        end
    end

    assign rec_valid = (is_sep || end_of_sentence) && active;

    always_comb
    begin
        rec.field_index = taken.field_counter;
        rec.present = (taken.char_position != 8'd0);
        rec.part_a = taken.accum_a;
        rec.part_b = taken.accum_b;
        rec.part_c = taken.accum_c;
        rec.part_d = taken.accum_d;
        rec.first_char = taken.first_seen_char;
        rec.text = taken.text_shift;
        rec.last_of_sentence = end_of_sentence;
    end

    always_comb
    begin
        state_next = taken;
        if (end_of_sentence || is_sep)
        begin
            state_next = '0;
            if (!end_of_sentence && active)
                state_next.field_counter = state_cur.field_counter + 4'd1;
            else if (!end_of_sentence)
                state_next.field_counter = state_cur.field_counter;
        end
    end

endmodule

`default_nettype wire

### rtl/core/nmea_rmc_field_parser.sv
// Top level of the RMC sentence field parser: input register, decode step, result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes an RMC sentence one character per word on the slave stream (tlast marks the
// sentence's last character) and sends one record word per finished field on the master
// stream, with tlast set on the record of the sentence's final field. A new character is
// accepted in every cycle unless a record waits for the master; a record's closing character
// passes through the input register and then the decode step, which feeds the result register.
// Throughput is set only by the master side: while a record waits for the master, the
// decode step stops and the input register holds one more character; with the master
// ready, a character can follow in every cycle. The separator register may be
// rewritten only while no character is in flight.
module nmea_rmc_field_parser
    import nrfp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [7:0]            cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic                  s_axis_tlast,   // end_of_sentence
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [3:0] field_index, [4] present, [24:5] part_a, [44:25] part_b, [64:45] part_c,
    // [84:65] part_d, [92:85] first_char, [156:93] text, [159:157] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast    // last_of_sentence
);

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_eos_reg;
    logic [7:0]   separator_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    field_rec_t   rec_next;
    logic         rec_valid;
    logic         out_valid_reg;
    field_rec_t   out_rec_reg;
    logic         can_advance;
    logic         step;

    assign can_advance = !out_valid_reg || m_axis_tready;
    assign step = in_valid_reg && can_advance;
    assign s_axis_tready = !in_valid_reg || can_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            separator_reg <= SEPARATOR_RESET;
        else if (cfg_we)
            separator_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata[7:0];
            in_eos_reg <= s_axis_tlast;
        end
    end

    nrfp_field_decode u_decode (
        .state_cur       (state_reg),
        .char_code       (in_char_reg),
        .end_of_sentence (in_eos_reg),
        .separator_char  (separator_reg),
        .state_next      (state_next),
        .rec             (rec_next),
        .rec_valid       (rec_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (can_advance)
            out_valid_reg <= step && rec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && rec_valid)
            out_rec_reg <= rec_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast = out_rec_reg.last_of_sentence;
    assign m_axis_tdata = {3'b000, out_rec_reg.text, out_rec_reg.first_char,
                           out_rec_reg.part_d, out_rec_reg.part_c, out_rec_reg.part_b,
                           out_rec_reg.part_a, out_rec_reg.present, out_rec_reg.field_index};

    // The field counter stops at the first position that yields no record.
    a_counter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.field_counter <= 4'(FIELD_COUNT))
        else $error("field counter ran past its limit");

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_eos_reg) |=> (state_reg.field_counter == 4'd0
                                  && state_reg.char_position == 8'd0))
        else $error("state not cleared after end of sentence");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rec_reg.field_index <= FIELD_LAST_KNOWN))
        else $error("record issued for a dropped field");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !can_advance) |=> (in_valid_reg && $stable(in_char_reg)
                                            && $stable(in_eos_reg)))
        else $error("waiting character lost");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_rec_reg)))
        else $error("pending record overwritten");

endmodule

`default_nettype wire
